FILE: hdl/e2q_pkg.sv
// Shared constants, types and functions for the Euler angle to quaternion converter.
package e2q_pkg;

	localparam int ANGLE_WIDTH = 16;
	localparam int COMPONENT_FRAC_BITS = 14;
	localparam int CORDIC_STEPS = 16;
	localparam int FIELD_WIDTH = 16;
	localparam int CS_WIDTH = 32;
	localparam int PHASE_WIDTH = 33;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;
	localparam logic signed [CS_WIDTH-1:0] GAIN_Q30 = 32'sd652032874;

	typedef logic signed [FIELD_WIDTH-1:0] field_t;
	typedef logic signed [CS_WIDTH-1:0] cs_t;
	typedef logic signed [PHASE_WIDTH-1:0] phase_t;

	typedef struct packed {
		phase_t roll;
		phase_t pitch;
		phase_t yaw;
	} half_set_t;

	typedef struct packed {
		logic valid;
		logic pop;
	} queue_ctl_t;

	function automatic phase_t atan_turns(input int i);
		unique case (i)
			0: atan_turns = 33'sd536870912;
			1: atan_turns = 33'sd316933406;
			2: atan_turns = 33'sd167458907;
			3: atan_turns = 33'sd85004756;
			4: atan_turns = 33'sd42667331;
			5: atan_turns = 33'sd21354465;
			6: atan_turns = 33'sd10679838;
			7: atan_turns = 33'sd5340245;
			8: atan_turns = 33'sd2670163;
			9: atan_turns = 33'sd1335087;
			10: atan_turns = 33'sd667544;
			11: atan_turns = 33'sd333772;
			12: atan_turns = 33'sd166886;
			13: atan_turns = 33'sd83443;
			14: atan_turns = 33'sd41722;
			15: atan_turns = 33'sd20861;
			16: atan_turns = 33'sd10430;
			17: atan_turns = 33'sd5215;
			18: atan_turns = 33'sd2608;
			19: atan_turns = 33'sd1304;
			20: atan_turns = 33'sd652;
			21: atan_turns = 33'sd326;
			22: atan_turns = 33'sd163;
			23: atan_turns = 33'sd81;
			24: atan_turns = 33'sd41;
			25: atan_turns = 33'sd20;
			26: atan_turns = 33'sd10;
			27: atan_turns = 33'sd5;
			28: atan_turns = 33'sd3;
			29: atan_turns = 33'sd1;
			30: atan_turns = 33'sd1;
			default: atan_turns = 33'sd0;
		endcase
	endfunction

	// Binary angle to half-angle phase, 2^32 a full turn.
	function automatic phase_t half_phase(input field_t a);
		logic signed [ANGLE_WIDTH-1:0] v;
		v = a[ANGLE_WIDTH-1:0];
		half_phase = phase_t'(v) <<< (31 - ANGLE_WIDTH);
	endfunction

endpackage

FILE: hdl/e2q_front.sv
// Front end: takes a beat, halves the angles and queues them for the back end.
module e2q_front import e2q_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  field_t     roll_angle,
	input  field_t     pitch_angle,
	input  field_t     yaw_angle,
	input  logic       pop,
	output logic       busy,
	output queue_ctl_t qctl,
	output half_set_t  head
);

	half_set_t mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0] count_q;
	logic push;
	logic take;

	assign busy = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign take = start && !busy;
	assign push = take;
	assign qctl.valid = (count_q != '0);
	assign qctl.pop = pop && qctl.valid;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{half_phase(roll_angle), half_phase(pitch_angle),
				half_phase(yaw_angle)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (qctl.pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(qctl.pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH)) else $error("queue overflow");
	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> qctl.valid) else $error("busy while empty");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !qctl.pop) else $error("pop of empty queue");

endmodule

FILE: hdl/e2q_cordic.sv
// Pipelined CORDIC in rotation mode: cosine and sine of three half-angles.
module e2q_cordic import e2q_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  half_set_t in_half,
	output logic      out_valid,
	output cs_t       cos_out [3],
	output cs_t       sin_out [3]
);

	cs_t    x_q [CORDIC_STEPS][3];
	cs_t    y_q [CORDIC_STEPS][3];
	phase_t z_q [CORDIC_STEPS][3];
	logic   v_q [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		cs_t    x_in [3];
		cs_t    y_in [3];
		phase_t z_in [3];
		logic   v_in;

		if (i == 0) begin : g_first
			always_comb begin
				v_in = in_valid;
				for (int k = 0; k < 3; k++) begin
					x_in[k] = GAIN_Q30;
					y_in[k] = '0;
				end
				z_in[0] = in_half.roll;
				z_in[1] = in_half.pitch;
				z_in[2] = in_half.yaw;
			end
		end else begin : g_next
			always_comb begin
				v_in = v_q[i-1];
				for (int k = 0; k < 3; k++) begin
					x_in[k] = x_q[i-1][k];
					y_in[k] = y_q[i-1][k];
					z_in[k] = z_q[i-1][k];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else begin
				v_q[i] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			for (int k = 0; k < 3; k++) begin
				if (!z_in[k][PHASE_WIDTH-1]) begin
					x_q[i][k] <= x_in[k] - (y_in[k] >>> i);
					y_q[i][k] <= y_in[k] + (x_in[k] >>> i);
					z_q[i][k] <= z_in[k] - atan_turns(i);
				end else begin
					x_q[i][k] <= x_in[k] + (y_in[k] >>> i);
					y_q[i][k] <= y_in[k] - (x_in[k] >>> i);
					z_q[i][k] <= z_in[k] + atan_turns(i);
				end
			end
		end
	end

	assign out_valid = v_q[CORDIC_STEPS-1];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cos_out[k] = x_q[CORDIC_STEPS-1][k];
			sin_out[k] = y_q[CORDIC_STEPS-1][k];
		end
	end

endmodule

FILE: hdl/e2q_combine.sv
// Product stages: pair products, triple products, rounding and saturation.
module e2q_combine import e2q_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  cs_t    cos_in [3],
	input  cs_t    sin_in [3],
	output logic   out_valid,
	output field_t w_out,
	output field_t x_out,
	output field_t y_out,
	output field_t z_out
);

	localparam int SH = 60 - COMPONENT_FRAC_BITS;
	localparam logic signed [63:0] ONE = 64'sd1 <<< COMPONENT_FRAC_BITS;
	localparam logic signed [63:0] HI = (ONE > 64'sd32767) ? 64'sd32767 : ONE;
	localparam logic signed [63:0] LO = (ONE > 64'sd32768) ? -64'sd32768 : -ONE;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [63:0] cycp_s1, sysp_s1, sycp_s1, cysp_s1;
	cs_t cycp_s2, sysp_s2, sycp_s2, cysp_s2;
	cs_t cr_s1, sr_s1, cr_s2, sr_s2;
	logic signed [63:0] prod_s3 [8];
	field_t res_s4 [4];

	function automatic field_t finish(input logic signed [63:0] s);
		logic signed [63:0] r;
		r = (s + (64'sd1 <<< (SH - 1))) >>> SH;
		if (r > HI) r = HI;
		if (r < LO) r = LO;
		finish = field_t'(r);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		cycp_s1 <= 64'(cos_in[2]) * 64'(cos_in[1]);
		sysp_s1 <= 64'(sin_in[2]) * 64'(sin_in[1]);
		sycp_s1 <= 64'(sin_in[2]) * 64'(cos_in[1]);
		cysp_s1 <= 64'(cos_in[2]) * 64'(sin_in[1]);
		cr_s1 <= cos_in[0];
		sr_s1 <= sin_in[0];
		cycp_s2 <= cs_t'((cycp_s1 + (64'sd1 <<< 29)) >>> 30);
		sysp_s2 <= cs_t'((sysp_s1 + (64'sd1 <<< 29)) >>> 30);
		sycp_s2 <= cs_t'((sycp_s1 + (64'sd1 <<< 29)) >>> 30);
		cysp_s2 <= cs_t'((cysp_s1 + (64'sd1 <<< 29)) >>> 30);
		cr_s2 <= cr_s1;
		sr_s2 <= sr_s1;
		prod_s3[0] <= 64'(cycp_s2) * 64'(cr_s2);
		prod_s3[1] <= 64'(sysp_s2) * 64'(sr_s2);
		prod_s3[2] <= 64'(cycp_s2) * 64'(sr_s2);
		prod_s3[3] <= 64'(sysp_s2) * 64'(cr_s2);
		prod_s3[4] <= 64'(sycp_s2) * 64'(sr_s2);
		prod_s3[5] <= 64'(cysp_s2) * 64'(cr_s2);
		prod_s3[6] <= 64'(sycp_s2) * 64'(cr_s2);
		prod_s3[7] <= 64'(cysp_s2) * 64'(sr_s2);
		res_s4[0] <= finish(prod_s3[0] + prod_s3[1]);
		res_s4[1] <= finish(prod_s3[2] - prod_s3[3]);
		res_s4[2] <= finish(prod_s3[4] + prod_s3[5]);
		res_s4[3] <= finish(prod_s3[6] - prod_s3[7]);
	end

	assign out_valid = valid_s4;
	assign w_out = res_s4[0];
	assign x_out = res_s4[1];
	assign y_out = res_s4[2];
	assign z_out = res_s4[3];

endmodule

FILE: hdl/euler_to_quaternion.sv
// Top level: Euler angles (Z-Y-X) to unit quaternion converter.
// One beat is taken per cycle while busy is low. Each result appears on done for one cycle,
// once its beat has passed one register in the input queue, CORDIC_STEPS (16) in the CORDIC
// and four in the product stages. The receiver cannot stall, so the queue drains every cycle
// and busy never rises; beats may follow back to back with no gap.
module euler_to_quaternion import e2q_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  field_t roll_angle,
	input  field_t pitch_angle,
	input  field_t yaw_angle,
	output logic   busy,
	output logic   done,
	output field_t quat_w,
	output field_t quat_x,
	output field_t quat_y,
	output field_t quat_z
);

	queue_ctl_t qctl;
	half_set_t  head;
	logic       cs_valid;
	cs_t        cos_v [3];
	cs_t        sin_v [3];

	e2q_front u_front (
		.clk, .arst_n, .start, .roll_angle, .pitch_angle, .yaw_angle,
		.pop(1'b1), .busy, .qctl, .head
	);

	e2q_cordic u_cordic (
		.clk, .arst_n, .in_valid(qctl.pop), .in_half(head),
		.out_valid(cs_valid), .cos_out(cos_v), .sin_out(sin_v)
	);

	e2q_combine u_combine (
		.clk, .arst_n, .in_valid(cs_valid), .cos_in(cos_v), .sin_in(sin_v),
		.out_valid(done), .w_out(quat_w), .x_out(quat_x), .y_out(quat_y), .z_out(quat_z)
	);

endmodule

FILE: verif/tb.sv
// Testbench for the Euler angle to quaternion converter: directed table plus random beats vs. predictor.
module tb;
	import e2q_pkg::*;

	typedef struct {
		logic signed [15:0] w, x, y, z;
	} quat_t;

	typedef struct {
		logic signed [15:0] roll, pitch, yaw;
		bit known;
		logic signed [15:0] w, x, y, z;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	field_t roll_angle = '0;
	field_t pitch_angle = '0;
	field_t yaw_angle = '0;
	logic busy, done;
	field_t quat_w, quat_x, quat_y, quat_z;

	quat_t expected_quats[$];
	int errors = 0;
	int send_idle = 0;

	euler_to_quaternion DUT (
		.clk(clk), .arst_n(arst_n), .start(start),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
		.busy(busy), .done(done),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
	);

	always #1 clk = ~clk;

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint arctan_turn(int i);
		longint t[32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
			20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
		return t[i];
	endfunction

	function automatic void cos_sin_half(input logic signed [15:0] a, output longint c,
			output longint s);
		longint xv, yv, zv, dx, dy;
		xv = 652032874;
		yv = 0;
		zv = longint'(a) * (longint'(1) << (31 - ANGLE_WIDTH));
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = fshr(yv, i);
			dy = fshr(xv, i);
			if (zv >= 0) begin
				xv -= dx; yv += dy; zv -= arctan_turn(i);
			end else begin
				xv += dx; yv -= dy; zv += arctan_turn(i);
			end
		end
		c = xv;
		s = yv;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return fshr(a * b + (longint'(1) << 29), 30);
	endfunction

	function automatic logic signed [15:0] round_clamp(longint sum);
		int sh;
		longint r, one;
		sh = 60 - COMPONENT_FRAC_BITS;
		r = fshr(sum + (longint'(1) << (sh - 1)), sh);
		one = longint'(1) << COMPONENT_FRAC_BITS;
		if (r > one) r = one;
		if (r < -one) r = -one;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic quat_t euler_quat(logic signed [15:0] r, p, y);
		longint cr, sr, cp, sp, cy, sy, cycp, sysp, sycp, cysp;
		quat_t q;
		cos_sin_half(r, cr, sr);
		cos_sin_half(p, cp, sp);
		cos_sin_half(y, cy, sy);
		cycp = qmul(cy, cp);
		sysp = qmul(sy, sp);
		sycp = qmul(sy, cp);
		cysp = qmul(cy, sp);
		q.w = round_clamp(cycp * cr + sysp * sr);
		q.x = round_clamp(cycp * sr - sysp * cr);
		q.y = round_clamp(sycp * sr + cysp * cr);
		q.z = round_clamp(sycp * cr - cysp * sr);
		return q;
	endfunction

	always @(posedge clk) begin
		quat_t e;
		if (done) begin
			if (expected_quats.size() == 0) begin
				$error("result with no beat pending");
				errors++;
			end else begin
				e = expected_quats.pop_front();
				if (quat_w !== e.w) begin
					$error("quat_w expected %0d actual %0d", e.w, quat_w); errors++;
				end
				if (quat_x !== e.x) begin
					$error("quat_x expected %0d actual %0d", e.x, quat_x); errors++;
				end
				if (quat_y !== e.y) begin
					$error("quat_y expected %0d actual %0d", e.y, quat_y); errors++;
				end
				if (quat_z !== e.z) begin
					$error("quat_z expected %0d actual %0d", e.z, quat_z); errors++;
				end
			end
		end
	end

	task automatic send_beat(input logic signed [15:0] r, p, y, input quat_t q);
		if ($urandom_range(99) < send_idle) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		start <= 1'b1;
		roll_angle <= r;
		pitch_angle <= p;
		yaw_angle <= y;
		do @(posedge clk); while (busy);
		expected_quats.push_back(q);
	endtask

	row_t directed[] = '{
		'{16'sd0, 16'sd0, 16'sd0, 1'b0, 0, 0, 0, 0},
		'{-16'sd32768, 16'sd0, 16'sd0, 1'b0, 0, 0, 0, 0},
		'{16'sd0, -16'sd32768, 16'sd0, 1'b0, 0, 0, 0, 0},
		'{16'sd0, 16'sd0, -16'sd32768, 1'b0, 0, 0, 0, 0},
		'{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 0, 0, 0, 0},
		'{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 0, 0, 0, 0},
		'{16'sd16384, 16'sd0, 16'sd0, 1'b0, 0, 0, 0, 0},
		'{16'sd0, 16'sd16384, 16'sd0, 1'b0, 0, 0, 0, 0},
		'{16'sd0, 16'sd0, 16'sd16384, 1'b0, 0, 0, 0, 0},
		'{-16'sd16384, 16'sd16384, -16'sd16384, 1'b0, 0, 0, 0, 0},
		'{16'sd1, -16'sd1, 16'sd1, 1'b0, 0, 0, 0, 0},
		'{16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, 0, 0, 0, 0},
		'{16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0, 0, 0, 0, 0},
		'{16'sd8192, 16'sd8192, 16'sd8192, 1'b0, 0, 0, 0, 0}
	};

	initial begin
		quat_t q;
		logic signed [15:0] r, p, y;
		int idle_mix[4] = '{0, 66, 0, 19};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			q = euler_quat(directed[i].roll, directed[i].pitch, directed[i].yaw);
			if (directed[i].known) begin
				q.w = directed[i].w; q.x = directed[i].x;
				q.y = directed[i].y; q.z = directed[i].z;
			end
			send_beat(directed[i].roll, directed[i].pitch, directed[i].yaw, q);
		end
		start <= 1'b0;
		// hold until every pending result has drained
		while (expected_quats.size() != 0) @(posedge clk);
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = idle_mix[ph];
			for (int n = 0; n < 125; n++) begin
				r = 16'($urandom); p = 16'($urandom); y = 16'($urandom);
				if ($urandom_range(9) == 0) p = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
				send_beat(r, p, y, euler_quat(r, p, y));
			end
		end
		start <= 1'b0;
		while (expected_quats.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#200000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
